[hdl/accfd_pkg.sv]
// accfd_pkg: widths, reset values, register indexes and helpers for the
// accelerometer fall and activity detector; no dependencies
package accfd_pkg;

    localparam int AXIS_W    = 13;
    localparam int MAG_W     = 14;
    localparam int THR_W     = 14;
    localparam int CNT_W     = 11;
    localparam int STEP_W    = 8;
    localparam int WCNT_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 14;

    localparam int WINDOW_LEN_DEF = 25;

    localparam logic [THR_W-1:0]  QUIET_THR_RST   = THR_W'(328);
    localparam logic [THR_W-1:0]  PEAK_THR_RST    = THR_W'(6000);
    localparam logic [CNT_W-1:0]  CEILING_RST     = CNT_W'(1200);
    localparam logic [STEP_W-1:0] WAKE_STEP_RST   = STEP_W'(20);
    localparam logic [WCNT_W-1:0] REPORT_WIN_RST  = WCNT_W'(60);
    localparam logic [CNT_W-1:0]  RESTING_INIT    = CNT_W'(1200);
    localparam logic [MAG_W-1:0]  MIN_INIT        = {MAG_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUIET_THR  = 3'd0,
        CFG_PEAK_THR   = 3'd1,
        CFG_CEILING    = 3'd2,
        CFG_WAKE_STEP  = 3'd3,
        CFG_REPORT_WIN = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [MAG_W-1:0] mean;
        logic [MAG_W-1:0] peak;
        logic [MAG_W-1:0] spread;
        logic             fall_alert;
        logic             report_valid;
        logic             user_resting;
        logic [CNT_W-1:0] resting_tally;
        logic [CNT_W-1:0] active_tally;
    } result_t;

    // magnitude of one 13-bit two's complement axis, -4096 gives 4096
    function automatic logic [AXIS_W-1:0] axis_mag(input logic [AXIS_W-1:0] a);
        logic [AXIS_W-1:0] neg;
        neg = ~a + AXIS_W'(1);
        return a[AXIS_W-1] ? neg : a;
    endfunction

endpackage

[hdl/accel_fall_and_activity_detector_core.sv]
// accel_fall_and_activity_detector_core: windowed magnitude statistics,
// fall stages and resting/active verdicts; depends on accfd_pkg
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------------
//  sample in | in_valid / in_ready    | accel_x, accel_y, accel_z
//  result    | out_valid / out_ready  | window_mean .. active_tally
//  config    | cfg_we                 | cfg_index, cfg_data
//
// one sample transfer per cycle while in_ready is high; after the last sample of a
// window is taken, its result passes the magnitude, snapshot and result registers
// stages: sample register, magnitude register, window snapshot, result register;
// the mean multiply by the window reciprocal sits between snapshot and result
// a stalled result holds the output register and ready falls back stage by stage
// reset sets window, fall stages, counters, config and valid bits to their defaults
module accel_fall_and_activity_detector_core
    import accfd_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [AXIS_W-1:0]     accel_x,
    input  logic [AXIS_W-1:0]     accel_y,
    input  logic [AXIS_W-1:0]     accel_z,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [MAG_W-1:0]      window_mean,
    output logic [MAG_W-1:0]      window_peak,
    output logic [MAG_W-1:0]      window_spread,
    output logic                  fall_alert,
    output logic                  report_valid,
    output logic                  user_resting,
    output logic [CNT_W-1:0]      resting_tally,
    output logic [CNT_W-1:0]      active_tally,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W     = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W     = MAG_W + $clog2(WINDOW_LEN);
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_LEN);
    localparam int RECIP     = ((1 << DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int PROD_W    = SUM_W + DIV_SHIFT;
    localparam logic [DIV_SHIFT-1:0] RECIP_C = DIV_SHIFT'(RECIP);
    localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(WINDOW_LEN);

    // configuration registers
    logic [THR_W-1:0]  quiet_thr_reg;
    logic [THR_W-1:0]  peak_thr_reg;
    logic [CNT_W-1:0]  ceiling_reg;
    logic [STEP_W-1:0] wake_step_reg;
    logic [WCNT_W-1:0] report_win_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_thr_reg  <= QUIET_THR_RST;
            peak_thr_reg   <= PEAK_THR_RST;
            ceiling_reg    <= CEILING_RST;
            wake_step_reg  <= WAKE_STEP_RST;
            report_win_reg <= REPORT_WIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_QUIET_THR:  quiet_thr_reg  <= cfg_data[THR_W-1:0];
                CFG_PEAK_THR:   peak_thr_reg   <= cfg_data[THR_W-1:0];
                CFG_CEILING:    ceiling_reg    <= cfg_data[CNT_W-1:0];
                CFG_WAKE_STEP:  wake_step_reg  <= cfg_data[STEP_W-1:0];
                CFG_REPORT_WIN: report_win_reg <= cfg_data[WCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s4_ok, s3_ok, s2_ok, s1_ok;
    logic s3_adv, s2_adv, s1_adv, in_xfer;

    assign s4_ok   = !out_valid_reg || out_ready;
    assign s3_adv  = s3_valid_reg && s4_ok;
    assign s3_ok   = !s3_valid_reg || s4_ok;
    assign s2_adv  = s2_valid_reg && s3_ok;
    assign s2_ok   = !s2_valid_reg || s3_ok;
    assign s1_adv  = s1_valid_reg && s2_ok;
    assign s1_ok   = !s1_valid_reg || s2_ok;
    assign in_ready = s1_ok;
    assign in_xfer  = in_valid && s1_ok;

    // stage 1: sample register
    logic [AXIS_W-1:0] ax_reg, ay_reg, az_reg;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
        end
    end

    // stage 2: magnitude register
    logic [MAG_W-1:0] mag_reg, mag_next;

    assign mag_next = MAG_W'(axis_mag(ax_reg)) + MAG_W'(axis_mag(ay_reg))
                    + MAG_W'(axis_mag(az_reg));

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            mag_reg <= mag_next;
    end

    // window accumulators
    logic [IDX_W-1:0] sample_idx_reg, sample_idx_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [MAG_W-1:0] max_reg, max_next;
    logic [MAG_W-1:0] min_reg, min_next;
    logic             win_end;

    always_comb
    begin
        sample_idx_next = sample_idx_reg + IDX_W'(1);
        sum_next        = sum_reg + SUM_W'(mag_reg);
        max_next        = (mag_reg >= max_reg) ? mag_reg : max_reg;
        min_next        = (mag_reg < min_reg) ? mag_reg : min_reg;
        win_end         = (sample_idx_next == LAST_IDX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_idx_reg <= '0;
            sum_reg        <= '0;
            max_reg        <= '0;
            min_reg        <= MIN_INIT;
        end
        else if (s2_adv)
        begin
            if (win_end)
            begin
                sample_idx_reg <= '0;
                sum_reg        <= '0;
                max_reg        <= '0;
                min_reg        <= MIN_INIT;
            end
            else
            begin
                sample_idx_reg <= sample_idx_next;
                sum_reg        <= sum_next;
                max_reg        <= max_next;
                min_reg        <= min_next;
            end
        end
    end

    // stage 3: window snapshot
    logic [SUM_W-1:0] snap_sum_reg;
    logic [MAG_W-1:0] snap_max_reg, snap_min_reg;

    always_ff @(posedge clk)
    begin
        if (s2_adv && win_end)
        begin
            snap_sum_reg <= sum_next;
            snap_max_reg <= max_next;
            snap_min_reg <= min_next;
        end
    end

    // per-window decisions
    logic [PROD_W-1:0] mean_prod;
    logic [MAG_W-1:0]  spread;
    logic              quiet;
    logic [CNT_W:0]    rest_plus_one, act_plus_step;
    logic [CNT_W-1:0]  resting_reg, resting_next;
    logic [CNT_W-1:0]  active_reg, active_next;
    logic              high_peak_reg, high_peak_next;
    logic              fall_poss_reg, fall_poss_next;
    logic [WCNT_W-1:0] wcount_reg, wcount_next, wcount_inc;
    logic              report_hit;
    result_t           res_next, res_reg;

    assign mean_prod = PROD_W'(snap_sum_reg) * PROD_W'(RECIP_C);

    always_comb
    begin
        spread        = snap_max_reg - snap_min_reg;
        quiet         = (spread <= quiet_thr_reg);
        rest_plus_one = {1'b0, resting_reg} + (CNT_W+1)'(1);
        act_plus_step = {1'b0, active_reg} + (CNT_W+1)'(wake_step_reg);
        resting_next  = resting_reg;
        active_next   = active_reg;
        if (quiet)
        begin
            if (rest_plus_one < {1'b0, ceiling_reg} && active_reg > CNT_W'(1))
            begin
                resting_next = rest_plus_one[CNT_W-1:0];
                active_next  = active_reg - CNT_W'(1);
            end
        end
        else if (act_plus_step < {1'b0, ceiling_reg}
                 && resting_reg > CNT_W'(wake_step_reg))
        begin
            resting_next = resting_reg - CNT_W'(wake_step_reg);
            active_next  = act_plus_step[CNT_W-1:0];
        end

        fall_poss_next = high_peak_reg && (snap_max_reg < peak_thr_reg);
        high_peak_next = (snap_max_reg >= peak_thr_reg);

        wcount_inc  = wcount_reg + WCNT_W'(1);
        report_hit  = (wcount_inc == report_win_reg);
        wcount_next = report_hit ? '0 : wcount_inc;

        res_next.mean          = mean_prod[DIV_SHIFT +: MAG_W];
        res_next.peak          = snap_max_reg;
        res_next.spread        = spread;
        res_next.fall_alert    = fall_poss_reg && quiet;
        res_next.report_valid  = report_hit;
        res_next.user_resting  = report_hit && (resting_next > active_next);
        res_next.resting_tally = resting_next;
        res_next.active_tally  = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resting_reg   <= RESTING_INIT;
            active_reg    <= '0;
            high_peak_reg <= 1'b0;
            fall_poss_reg <= 1'b0;
            wcount_reg    <= '0;
        end
        else if (s3_adv)
        begin
            resting_reg   <= resting_next;
            active_reg    <= active_next;
            high_peak_reg <= high_peak_next;
            fall_poss_reg <= fall_poss_next;
            wcount_reg    <= wcount_next;
        end
    end

    // stage 4: result register
    always_ff @(posedge clk)
    begin
        if (s3_adv)
            res_reg <= res_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ok)
                s1_valid_reg <= in_valid;
            if (s2_ok)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ok)
                s3_valid_reg <= s2_valid_reg && win_end;
            if (s4_ok)
                out_valid_reg <= s3_valid_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign window_mean   = res_reg.mean;
    assign window_peak   = res_reg.peak;
    assign window_spread = res_reg.spread;
    assign fall_alert    = res_reg.fall_alert;
    assign report_valid  = res_reg.report_valid;
    assign user_resting  = res_reg.user_resting;
    assign resting_tally = res_reg.resting_tally;
    assign active_tally  = res_reg.active_tally;

endmodule

[bench/accfd_window_checker.sv]
// accfd_window_checker: watches the sample, result and config ports of the
// detector core, predicts every window result and compares field by field
// depends on accfd_pkg
module accfd_window_checker
    import accfd_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [AXIS_W-1:0]     accel_x,
    input  logic [AXIS_W-1:0]     accel_y,
    input  logic [AXIS_W-1:0]     accel_z,

    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [MAG_W-1:0]      window_mean,
    input  logic [MAG_W-1:0]      window_peak,
    input  logic [MAG_W-1:0]      window_spread,
    input  logic                  fall_alert,
    input  logic                  report_valid,
    input  logic                  user_resting,
    input  logic [CNT_W-1:0]      resting_tally,
    input  logic [CNT_W-1:0]      active_tally,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    output int                    fail_count,
    output int                    pending
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [THR_W-1:0]  quiet_thr;
    logic [THR_W-1:0]  peak_thr;
    logic [CNT_W-1:0]  ceiling;
    logic [STEP_W-1:0] wake_step;
    logic [WCNT_W-1:0] report_win;

    logic [4:0]        sample_idx;
    logic [18:0]       mag_sum;
    logic [MAG_W-1:0]  mag_max;
    logic [MAG_W-1:0]  mag_min;
    logic              high_peak;
    logic              fall_armed;
    logic [WCNT_W-1:0] win_count;
    logic [CNT_W-1:0]  resting;
    logic [CNT_W-1:0]  active;

    result_t           expected_windows[$];

    initial fail_count = 0;
    initial pending = 0;

    function automatic logic [MAG_W-1:0] axis_size(input logic [AXIS_W-1:0] a);
        int v;
        v = $signed(a);
        return MAG_W'(v < 0 ? -v : v);
    endfunction

    task automatic clear_window();
        sample_idx = '0;
        mag_sum    = '0;
        mag_max    = '0;
        mag_min    = {MAG_W{1'b1}};
    endtask

    task automatic predict_sample(input logic [AXIS_W-1:0] x, y, z);
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] peak;
        logic [MAG_W-1:0] spread;
        logic             quiet;
        result_t          r;
        mag = axis_size(x) + axis_size(y) + axis_size(z);
        mag_sum = mag_sum + 19'(mag);
        if (mag >= mag_max)
            mag_max = mag;
        if (mag < mag_min)
            mag_min = mag;
        sample_idx = sample_idx + 5'd1;
        if (sample_idx >= WINDOW_LEN)
        begin
            r.mean   = MAG_W'(mag_sum / WINDOW_LEN);
            peak     = mag_max;
            spread   = mag_max - mag_min;
            clear_window();

            quiet = spread <= quiet_thr;
            if (quiet)
            begin
                if (int'(resting) + 1 < int'(ceiling) && active > 1)
                begin
                    resting = resting + 1'b1;
                    active  = active - 1'b1;
                end
            end
            else if (int'(active) + int'(wake_step) < int'(ceiling) && resting > wake_step)
            begin
                active  = active + CNT_W'(wake_step);
                resting = resting - CNT_W'(wake_step);
            end

            r.fall_alert = fall_armed && quiet;
            fall_armed   = high_peak && (peak < peak_thr);
            high_peak    = peak >= peak_thr;

            win_count      = win_count + 1'b1;
            r.report_valid = 1'b0;
            r.user_resting = 1'b0;
            if (win_count == report_win)
            begin
                win_count      = '0;
                r.report_valid = 1'b1;
                r.user_resting = resting > active;
            end

            r.peak          = peak;
            r.spread        = spread;
            r.resting_tally = resting;
            r.active_tally  = active;
            expected_windows.push_back(r);
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want, got,
                               inout bit bad);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d got %0d", $time, field, want, got);
            bad = 1'b1;
        end
    endtask

    task automatic check_result();
        result_t w;
        bit      bad;
        bad = 1'b0;
        if (expected_windows.size() == 0)
        begin
            $display("%0t ns: result transfer with none pending, mean %0d peak %0d",
                     $time, window_mean, window_peak);
            fail_count++;
        end
        else
        begin
            w = expected_windows.pop_front();
            check_field("window_mean", w.mean, window_mean, bad);
            check_field("window_peak", w.peak, window_peak, bad);
            check_field("window_spread", w.spread, window_spread, bad);
            check_field("fall_alert", w.fall_alert, fall_alert, bad);
            check_field("report_valid", w.report_valid, report_valid, bad);
            check_field("user_resting", w.user_resting, user_resting, bad);
            check_field("resting_tally", w.resting_tally, resting_tally, bad);
            check_field("active_tally", w.active_tally, active_tally, bad);
            if (bad)
                fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_thr  = QUIET_THR_RST;
            peak_thr   = PEAK_THR_RST;
            ceiling    = CEILING_RST;
            wake_step  = WAKE_STEP_RST;
            report_win = REPORT_WIN_RST;
            clear_window();
            high_peak  = 1'b0;
            fall_armed = 1'b0;
            win_count  = '0;
            resting    = RESTING_INIT;
            active     = '0;
            expected_windows.delete();
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_QUIET_THR:  quiet_thr  = THR_W'(cfg_data);
                    CFG_PEAK_THR:   peak_thr   = THR_W'(cfg_data);
                    CFG_CEILING:    ceiling    = CNT_W'(cfg_data);
                    CFG_WAKE_STEP:  wake_step  = STEP_W'(cfg_data);
                    CFG_REPORT_WIN: report_win = WCNT_W'(cfg_data);
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                predict_sample(accel_x, accel_y, accel_z);
            pending = expected_windows.size();
        end
    end

endmodule

[bench/tb_accel_fall_and_activity_detector_core.sv]
// tb_accel_fall_and_activity_detector_core: drives samples, config writes and
// result back-pressure into the detector core and reports the verdict
// depends on accfd_pkg, accel_fall_and_activity_detector_core, accfd_window_checker
module tb_accel_fall_and_activity_detector_core
    import accfd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN             = WINDOW_LEN_DEF;
    localparam int MAX_MAG         = 12288;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int NUM_PHASES      = 6;
    localparam int LONG_HOLD       = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 400000;

    typedef enum int {
        WIN_IMPACT,
        WIN_LOW,
        WIN_CALM,
        WIN_ACTIVE
    } window_kind_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [AXIS_W-1:0]     accel_x   = '0;
    logic [AXIS_W-1:0]     accel_y   = '0;
    logic [AXIS_W-1:0]     accel_z   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  in_ready;
    logic                  out_valid;
    logic [MAG_W-1:0]      window_mean;
    logic [MAG_W-1:0]      window_peak;
    logic [MAG_W-1:0]      window_spread;
    logic                  fall_alert;
    logic                  report_valid;
    logic                  user_resting;
    logic [CNT_W-1:0]      resting_tally;
    logic [CNT_W-1:0]      active_tally;

    int fail_count;
    int pending;
    int samples_sent  = 0;
    int hold_requests = 0;
    int no_gap_left   = 0;

    // quiet, peak, ceiling, wake step, report period
    int unsigned phase_settings [NUM_PHASES][5] = '{
        '{328,   6000,  1200, 20,  1},
        '{0,     12288, 2047, 255, 3},
        '{12288, 0,     1,    1,   2},
        '{150,   4000,  1500, 255, 0},
        '{400,   3000,  2047, 1,   7},
        '{328,   6000,  1200, 20,  60}
    };

    int directed_samples [25][3] = '{
        '{-4096, -4096, -4096}, '{4095, 4095, 4095}, '{0, 0, 0},
        '{-1, 0, 0}, '{0, -1, 0}, '{0, 0, -1},
        '{4095, -4096, 0}, '{-4096, 0, 4095}, '{0, 4095, -4096},
        '{1, 1, 1}, '{-1, -1, -1}, '{2048, -2048, 1024},
        '{-4096, 4095, -4096}, '{4095, -4096, 4095}, '{0, 0, 4095},
        '{0, -4096, 0}, '{-4096, 0, 0}, '{1365, -2730, 4095},
        '{-4095, -4095, -4095}, '{4094, 0, -1}, '{-2, 3, -4},
        '{0, 0, 0}, '{4095, 4095, -4096}, '{-1000, 2000, -3000},
        '{-4096, -4096, -4096}
    };

    accel_fall_and_activity_detector_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .window_mean   (window_mean),
        .window_peak   (window_peak),
        .window_spread (window_spread),
        .fall_alert    (fall_alert),
        .report_valid  (report_valid),
        .user_resting  (user_resting),
        .resting_tally (resting_tally),
        .active_tally  (active_tally),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    accfd_window_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .window_mean   (window_mean),
        .window_peak   (window_peak),
        .window_spread (window_spread),
        .fall_alert    (fall_alert),
        .report_valid  (report_valid),
        .user_resting  (user_resting),
        .resting_tally (resting_tally),
        .active_tally  (active_tally),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (no_gap_left > 0)
        begin
            no_gap_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            no_gap_left = 40;
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [AXIS_W-1:0] signed_axis(input int mag);
        if (mag == 4096 || (mag != 0 && $urandom_range(0, 1) == 1))
            return AXIS_W'(-mag);
        return AXIS_W'(mag);
    endfunction

    task automatic send_sample(input logic [AXIS_W-1:0] x, y, z);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        accel_x  <= x;
        accel_y  <= y;
        accel_z  <= z;
        do
            @(posedge clk);
        while (!in_ready);
        samples_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // split a magnitude over three axes, each at most 4096
    task automatic send_magnitude(input int m);
        int px;
        int py;
        int rest;
        px   = $urandom_range(m > 8192 ? m - 8192 : 0, m < 4096 ? m : 4096);
        rest = m - px;
        py   = $urandom_range(rest > 4096 ? rest - 4096 : 0, rest < 4096 ? rest : 4096);
        send_sample(signed_axis(px), signed_axis(py), signed_axis(rest - py));
    endtask

    task automatic send_window(input window_kind_t kind);
        int n;
        int base;
        int jitter;
        int spike_at;
        int m;
        n        = WIN - (samples_sent % WIN);
        spike_at = $urandom_range(0, n - 1);
        jitter   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 400);
        case (kind)
            WIN_IMPACT: base = $urandom_range(0, 3000);
            WIN_LOW:    base = $urandom_range(0, 2500);
            default:    base = $urandom_range(0, MAX_MAG);
        endcase
        for (int i = 0; i < n; i++)
        begin
            if (kind == WIN_ACTIVE)
                m = $urandom_range(0, MAX_MAG);
            else if (kind == WIN_IMPACT && i == spike_at)
                m = ($urandom_range(0, 3) == 0) ? MAX_MAG : $urandom_range(5000, MAX_MAG);
            else
                m = base + $urandom_range(0, jitter);
            send_magnitude(m > MAX_MAG ? MAX_MAG : m);
        end
    endtask

    task automatic send_noise_burst();
        int n;
        n = $urandom_range(1, 40);
        repeat (n)
            send_sample(AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom));
    endtask

    task automatic settle_for_config();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
    endtask

    task automatic run_random_phase();
        int start;
        int r;
        start = samples_sent;
        while (samples_sent - start < ITEMS_PER_PHASE)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                send_window(WIN_IMPACT);
                send_window(WIN_LOW);
                send_window(WIN_LOW);
            end
            else if (r < 55)
                send_window(WIN_CALM);
            else if (r < 80)
                send_window(WIN_ACTIVE);
            else
                send_noise_burst();
        end
    endtask

    // result side back-pressure, with one long hold-off on request
    initial
    begin
        int run_left;
        bit run_ready;
        int holds_done;
        int r;
        run_left   = 0;
        run_ready  = 1'b1;
        holds_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_requests > holds_done)
            begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                if (run_left == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 55)
                    begin
                        run_ready = 1'b1;
                        run_left  = $urandom_range(1, 30);
                    end
                    else if (r < 85)
                    begin
                        run_ready = 1'b0;
                        run_left  = $urandom_range(1, 3);
                    end
                    else if (r < 95)
                    begin
                        run_ready = 1'b0;
                        run_left  = $urandom_range(4, 10);
                    end
                    else
                    begin
                        run_ready = 1'b0;
                        run_left  = $urandom_range(20, 60);
                    end
                end
                out_ready <= run_ready;
                run_left--;
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 25; i++)
            send_sample(AXIS_W'(directed_samples[i][0]), AXIS_W'(directed_samples[i][1]),
                        AXIS_W'(directed_samples[i][2]));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle_for_config();
            write_reg(CFG_QUIET_THR, phase_settings[p][0]);
            write_reg(CFG_PEAK_THR, phase_settings[p][1]);
            write_reg(CFG_CEILING, phase_settings[p][2]);
            write_reg(CFG_WAKE_STEP, phase_settings[p][3]);
            write_reg(CFG_REPORT_WIN, phase_settings[p][4]);
            @(negedge clk);
            cfg_we <= 1'b0;
            // fill the pipeline against a stalled result port
            if (p == 1)
                hold_requests++;
            run_random_phase();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
